// File: rtl/core/rgbds_pkg.sv
// Shared types and constants for the RGB565 nearest-neighbor gray downscaler.
package rgbds_pkg;

	// Fixed field widths
	localparam int PIX_W     = 16;
	localparam int GRAY_W    = 8;
	localparam int OUT_X_W   = 7;
	localparam int OUT_Y_W   = 7;
	localparam int SIZE_W    = 12;
	localparam int COL_W     = 11;
	localparam int CFG_IDX_W = 1;

	// Source size limits
	localparam int SRC_MAX = 2048;

	// Default output size
	localparam int OUT_WIDTH_DEF  = 96;
	localparam int OUT_HEIGHT_DEF = 96;

	// Register reset values
	localparam logic [SIZE_W-1:0] SRC_WIDTH_RST  = SIZE_W'(320);
	localparam logic [SIZE_W-1:0] SRC_HEIGHT_RST = SIZE_W'(240);

	// Luma weights (sum to 256)
	localparam int R_COEF = 77;
	localparam int G_COEF = 151;
	localparam int B_COEF = 28;
	localparam int SUM_W  = 17;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH  = 1'b0,
		CFG_SRC_HEIGHT = 1'b1
	} cfg_idx_t;

	// Selection result handed from the selector to the output register
	typedef struct packed {
		logic               hit;
		logic               last;
		logic [OUT_X_W-1:0] x;
		logic [OUT_Y_W-1:0] y;
	} sel_res_t;

endpackage

// File: rtl/core/rgbds_if.sv
// Valid/ready channel interfaces for source pixels and gray samples.
interface rgbds_pix_if import rgbds_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;

	modport source (output valid, pixel, frame_start, input ready);
	modport sink (input valid, pixel, frame_start, output ready);
endinterface

interface rgbds_smp_if import rgbds_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [GRAY_W-1:0]  gray;
	logic [OUT_X_W-1:0] out_x;
	logic [OUT_Y_W-1:0] out_y;
	logic               last;

	modport source (output valid, gray, out_x, out_y, last, input ready);
	modport sink (input valid, gray, out_x, out_y, last, output ready);
endinterface

// File: rtl/core/rgbds_gray.sv
// RGB565 to 8-bit gray conversion with BT.601 integer weights.
module rgbds_gray import rgbds_pkg::*; (
	input  logic [PIX_W-1:0]  pixel,
	output logic [GRAY_W-1:0] gray
);

	logic [7:0]       r8;
	logic [7:0]       g8;
	logic [7:0]       b8;
	logic [SUM_W-1:0] sum;

	// Expand channels to 8 bits
	assign r8 = {pixel[15:11], 3'b000};
	assign g8 = {pixel[10:5], 2'b00};
	assign b8 = {pixel[4:0], 3'b000};

	// Weighted sum, keep the high byte
	assign sum = SUM_W'(r8) * SUM_W'(R_COEF)
	           + SUM_W'(g8) * SUM_W'(G_COEF)
	           + SUM_W'(b8) * SUM_W'(B_COEF);
	assign gray = sum[15:8];

endmodule

// File: rtl/core/rgbds_sel.sv
// Source position counters and nearest-neighbor pick logic.
// Rather than dividing the accumulators, the source position is kept
// pre-scaled by the output size: a pick happens when
// pos*OUT <= acc < (pos+1)*OUT.
module rgbds_sel import rgbds_pkg::*; #(
	parameter int OUT_WIDTH  = OUT_WIDTH_DEF,
	parameter int OUT_HEIGHT = OUT_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              start,
	input  logic [SIZE_W-1:0] w,
	input  logic [SIZE_W-1:0] h,
	output sel_res_t          res
);

	localparam int OCW = $clog2(OUT_WIDTH + 1);
	localparam int ORW = $clog2(OUT_HEIGHT + 1);
	localparam int CAW = $clog2(SRC_MAX * OUT_WIDTH + 1);
	localparam int RAW = $clog2(SRC_MAX * OUT_HEIGHT + 1);

	localparam logic [OCW-1:0] OCOL_END  = OCW'(OUT_WIDTH);
	localparam logic [ORW-1:0] OROW_END  = ORW'(OUT_HEIGHT);
	localparam logic [OCW-1:0] OCOL_LAST = OCW'(OUT_WIDTH - 1);
	localparam logic [ORW-1:0] OROW_LAST = ORW'(OUT_HEIGHT - 1);
	localparam logic [CAW-1:0] COL_STEP  = CAW'(OUT_WIDTH);
	localparam logic [RAW-1:0] ROW_STEP  = RAW'(OUT_HEIGHT);
	localparam logic [COL_W-1:0] ROW_SAT = COL_W'(SRC_MAX - 1);

	logic [COL_W-1:0] col_q, row_q, col_e, row_e;
	logic [OCW-1:0]   ocol_q, ocol_e;
	logic [ORW-1:0]   orow_q, orow_e;
	logic [CAW-1:0]   col_acc_q, col_scl_q, col_acc_e, col_scl_e;
	logic [RAW-1:0]   row_acc_q, row_scl_q, row_acc_e, row_scl_e;
	logic             row_hit, col_hit, row_end;

	// Frame start clears everything before this pixel is looked at
	always_comb begin
		col_e     = start ? '0 : col_q;
		row_e     = start ? '0 : row_q;
		ocol_e    = start ? '0 : ocol_q;
		orow_e    = start ? '0 : orow_q;
		col_acc_e = start ? '0 : col_acc_q;
		col_scl_e = start ? '0 : col_scl_q;
		row_acc_e = start ? '0 : row_acc_q;
		row_scl_e = start ? '0 : row_scl_q;
	end

	// Pick decision
	assign row_hit = (orow_e < OROW_END) && (row_acc_e >= row_scl_e)
	               && ({1'b0, row_acc_e} < {1'b0, row_scl_e} + {1'b0, ROW_STEP});
	assign col_hit = row_hit && (ocol_e < OCOL_END) && (col_acc_e >= col_scl_e)
	               && ({1'b0, col_acc_e} < {1'b0, col_scl_e} + {1'b0, COL_STEP});
	assign row_end = {1'b0, col_e} >= (w - SIZE_W'(1));

	assign res.hit  = col_hit;
	assign res.last = (ocol_e == OCOL_LAST) && (orow_e == OROW_LAST);
	assign res.x    = OUT_X_W'(ocol_e);
	assign res.y    = OUT_Y_W'(orow_e);

	// Counter and accumulator update, once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			ocol_q    <= '0;
			orow_q    <= '0;
			col_acc_q <= '0;
			col_scl_q <= '0;
			row_acc_q <= '0;
			row_scl_q <= '0;
		end else if (adv) begin
			if (row_end) begin
				col_q     <= '0;
				col_scl_q <= '0;
				ocol_q    <= '0;
				col_acc_q <= '0;
				if (row_hit) begin
					orow_q    <= orow_e + ORW'(1);
					row_acc_q <= row_acc_e + RAW'(h);
				end else begin
					orow_q    <= orow_e;
					row_acc_q <= row_acc_e;
				end
				if (row_e < ROW_SAT) begin
					row_q     <= row_e + COL_W'(1);
					row_scl_q <= row_scl_e + ROW_STEP;
				end else begin
					row_q     <= row_e;
					row_scl_q <= row_scl_e;
				end
			end else begin
				col_q     <= col_e + COL_W'(1);
				col_scl_q <= col_scl_e + COL_STEP;
				row_q     <= row_e;
				row_scl_q <= row_scl_e;
				orow_q    <= orow_e;
				row_acc_q <= row_acc_e;
				if (col_hit) begin
					ocol_q    <= ocol_e + OCW'(1);
					col_acc_q <= col_acc_e + CAW'(w);
				end else begin
					ocol_q    <= ocol_e;
					col_acc_q <= col_acc_e;
				end
			end
		end
	end

endmodule

// File: rtl/core/rgb565_nearest_downscale_gray.sv
// Top level: RGB565 nearest-neighbor downscaler with gray output.
// Usage:
//   pixels  - sink channel, one RGB565 word per source pixel in raster order;
//             frame_start marks the first pixel of each frame.
//   samples - source channel, one gray word per picked pixel with its output
//             column, row and a last flag on the final sample of the frame.
//   cfg_*   - write port for src_width (index 0) and src_height (index 1);
//             values are clamped to [output size, 2048]; write while idle.
// Throughput: one pixel per clock while samples is not stalled. A pixel goes
// through an input register, the pick logic and gray conversion, and lands
// in the output register, from which its sample is shown on samples.
// The rate is set by the selector, which updates its counters once per pixel.
// When samples stalls, the output register holds its word and the input
// register holds the next pixel, picked or not; then pixels.ready drops,
// so at most two words wait inside the block.
// Reset: registers return to 320x240 and counters clear, so the first pixel
// after reset acts as the start of a frame.
module rgb565_nearest_downscale_gray import rgbds_pkg::*; #(
	parameter int OUT_WIDTH  = OUT_WIDTH_DEF,
	parameter int OUT_HEIGHT = OUT_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rgbds_pix_if.sink            pixels,
	rgbds_smp_if.source          samples,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data
);

	localparam logic [SIZE_W-1:0] W_MIN  = SIZE_W'(OUT_WIDTH);
	localparam logic [SIZE_W-1:0] H_MIN  = SIZE_W'(OUT_HEIGHT);
	localparam logic [SIZE_W-1:0] SZ_MAX = SIZE_W'(SRC_MAX);

	logic [SIZE_W-1:0] src_width_q, src_height_q, w, h;
	logic              valid_s1, start_s1, adv;
	logic [PIX_W-1:0]  pixel_s1;
	logic              valid_s2, last_s2;
	logic [GRAY_W-1:0] gray_s2, gray;
	logic [OUT_X_W-1:0] x_s2;
	logic [OUT_Y_W-1:0] y_s2;
	sel_res_t          res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_WIDTH_RST;
			src_height_q <= SRC_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SRC_WIDTH:  src_width_q  <= cfg_data;
				CFG_SRC_HEIGHT: src_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp sizes into the legal range
	assign w = (src_width_q < W_MIN) ? W_MIN : (src_width_q > SZ_MAX) ? SZ_MAX : src_width_q;
	assign h = (src_height_q < H_MIN) ? H_MIN
	         : (src_height_q > SZ_MAX) ? SZ_MAX : src_height_q;

	// Handshake: stage 1 moves on when the output register is free or draining
	assign adv          = valid_s1 && (!valid_s2 || samples.ready);
	assign pixels.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixels.ready && pixels.valid) begin
			pixel_s1 <= pixels.pixel;
			start_s1 <= pixels.frame_start;
		end
	end

	// Pick logic and gray conversion
	rgbds_sel #(
		.OUT_WIDTH  (OUT_WIDTH),
		.OUT_HEIGHT (OUT_HEIGHT)
	) u_sel (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.start  (start_s1),
		.w      (w),
		.h      (h),
		.res    (res)
	);

	rgbds_gray u_gray (
		.pixel (pixel_s1),
		.gray  (gray)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= res.hit;
		end else if (samples.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.hit) begin
			gray_s2 <= gray;
			x_s2    <= res.x;
			y_s2    <= res.y;
			last_s2 <= res.last;
		end
	end

	assign samples.valid = valid_s2;
	assign samples.gray  = gray_s2;
	assign samples.out_x = x_s2;
	assign samples.out_y = y_s2;
	assign samples.last  = last_s2;

endmodule
